// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/jrls_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package jrls_pkg;

  localparam int SAMPLE_W = 10;
  localparam int CENTRE_W = 10;
  localparam int DEAD_W   = 9;
  localparam int STEP_W   = 8;
  localparam int PERIOD_W = 7;
  localparam int LED_W    = 8;
  localparam int LEVEL_W  = 4;
  localparam int EDGE_W   = 12;  // signed band and dead band edges
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 3;

  localparam logic [CENTRE_W-1:0] CENTRE_RST = 10'd542;
  localparam logic [DEAD_W-1:0]   DEAD_RST   = 9'd100;
  localparam logic [CENTRE_W-1:0] LEFT_RST   = 10'd400;
  localparam logic [CENTRE_W-1:0] RIGHT_RST  = 10'd600;
  localparam logic [STEP_W-1:0]   STEP_RST   = 8'd100;

  localparam logic [INDEX_W-1:0] REG_CENTRE = 3'd0;
  localparam logic [INDEX_W-1:0] REG_DEAD   = 3'd1;
  localparam logic [INDEX_W-1:0] REG_LEFT   = 3'd2;
  localparam logic [INDEX_W-1:0] REG_RIGHT  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_STEP   = 3'd4;

  typedef struct packed {
    logic [CENTRE_W-1:0] centre_value;
    logic [DEAD_W-1:0]   dead_band;
    logic [CENTRE_W-1:0] left_band_top;
    logic [CENTRE_W-1:0] right_band_bottom;
    logic [STEP_W-1:0]   band_step;
  } cfg_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] lo;
    logic signed [EDGE_W-1:0] hi;
  } limits_t;

endpackage
`default_nettype wire

// ----- rtl/jrls_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
module jrls_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [jrls_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [jrls_pkg::DATA_W-1:0]   pwdata,
  output logic      [jrls_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output jrls_pkg::cfg_t                     cfg
);
  import jrls_pkg::*;

  logic               wr_en;
  logic [INDEX_W-1:0] index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre_value      <= CENTRE_RST;
      cfg.dead_band         <= DEAD_RST;
      cfg.left_band_top     <= LEFT_RST;
      cfg.right_band_bottom <= RIGHT_RST;
      cfg.band_step         <= STEP_RST;
    end else if (wr_en) begin
      unique case (index)
        REG_CENTRE: cfg.centre_value      <= pwdata[CENTRE_W-1:0];
        REG_DEAD:   cfg.dead_band         <= pwdata[DEAD_W-1:0];
        REG_LEFT:   cfg.left_band_top     <= pwdata[CENTRE_W-1:0];
        REG_RIGHT:  cfg.right_band_bottom <= pwdata[CENTRE_W-1:0];
        REG_STEP:   cfg.band_step         <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      REG_CENTRE: prdata = {{(DATA_W-CENTRE_W){1'b0}}, cfg.centre_value};
      REG_DEAD:   prdata = {{(DATA_W-DEAD_W){1'b0}}, cfg.dead_band};
      REG_LEFT:   prdata = {{(DATA_W-CENTRE_W){1'b0}}, cfg.left_band_top};
      REG_RIGHT:  prdata = {{(DATA_W-CENTRE_W){1'b0}}, cfg.right_band_bottom};
      REG_STEP:   prdata = {{(DATA_W-STEP_W){1'b0}}, cfg.band_step};
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/jrls_speed.sv -----
`timescale 1ns / 1ps
`default_nettype none
module jrls_speed (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           advance,
  input  wire logic [jrls_pkg::SAMPLE_W-1:0]  sample,
  input  wire jrls_pkg::cfg_t                 cfg,
  input  wire jrls_pkg::limits_t              limits,
  output logic      [jrls_pkg::PERIOD_W-1:0]  period_next,
  output logic      [jrls_pkg::LEVEL_W-1:0]   indicator_next
);
  import jrls_pkg::*;

  localparam logic [2:0] SP_START = 3'd0;
  localparam logic [2:0] SP_INIT  = 3'd1;
  localparam logic [2:0] SP_WAIT  = 3'd2;
  localparam logic [2:0] SP_LEFT  = 3'd3;
  localparam logic [2:0] SP_RIGHT = 3'd4;

  localparam logic [PERIOD_W-1:0] PER_SLOW = 7'd100;
  localparam logic [PERIOD_W-1:0] PER_MID  = 7'd50;
  localparam logic [PERIOD_W-1:0] PER_FAST = 7'd25;
  localparam logic [PERIOD_W-1:0] PER_TOP  = 7'd10;

  localparam logic [LEVEL_W-1:0] LVL_1 = 4'd1;
  localparam logic [LEVEL_W-1:0] LVL_2 = 4'd2;
  localparam logic [LEVEL_W-1:0] LVL_3 = 4'd4;
  localparam logic [LEVEL_W-1:0] LVL_4 = 4'd8;

  logic [2:0]              speed_phase, speed_phase_next;
  logic [PERIOD_W-1:0]     shift_period;
  logic [LEVEL_W-1:0]      indicator_bits;
  logic signed [EDGE_W-1:0] s, st1, st2, st3;
  logic signed [EDGE_W-1:0] l0, l1, l2, l3, r0, r1, r2, r3;

  assign s   = $signed({{(EDGE_W-SAMPLE_W){1'b0}}, sample});
  assign st1 = $signed({{(EDGE_W-STEP_W){1'b0}}, cfg.band_step});
  assign st2 = $signed({{(EDGE_W-STEP_W-1){1'b0}}, cfg.band_step, 1'b0});
  assign st3 = st1 + st2;

  // band edges, signed and unclipped
  assign l0 = $signed({{(EDGE_W-CENTRE_W){1'b0}}, cfg.left_band_top});
  assign l1 = l0 - st1;
  assign l2 = l0 - st2;
  assign l3 = l0 - st3;
  assign r0 = $signed({{(EDGE_W-CENTRE_W){1'b0}}, cfg.right_band_bottom});
  assign r1 = r0 + st1;
  assign r2 = r0 + st2;
  assign r3 = r0 + st3;

  always_comb begin
    unique case (speed_phase)
      SP_START: speed_phase_next = SP_INIT;
      SP_INIT:  speed_phase_next = SP_WAIT;
      SP_WAIT: begin
        if (s < limits.lo)      speed_phase_next = SP_LEFT;
        else if (s > limits.hi) speed_phase_next = SP_RIGHT;
        else                    speed_phase_next = SP_WAIT;
      end
      SP_LEFT, SP_RIGHT: speed_phase_next = SP_WAIT;
      default: speed_phase_next = SP_START;
    endcase
  end

  always_comb begin
    period_next    = shift_period;
    indicator_next = indicator_bits;
    if (speed_phase_next == SP_INIT) begin
      indicator_next = LVL_1;
      period_next    = '0;
    end else if (speed_phase_next == SP_LEFT) begin
      indicator_next = LVL_2;
      if (s <= l0 && s > l1) begin
        period_next = PER_SLOW; indicator_next = LVL_1;
      end else if (s <= l1 && s > l2) begin
        period_next = PER_MID;  indicator_next = LVL_2;
      end else if (s <= l2 && s > l3) begin
        period_next = PER_FAST; indicator_next = LVL_3;
      end else if (s <= l3) begin
        period_next = PER_TOP;  indicator_next = LVL_4;
      end
    end else if (speed_phase_next == SP_RIGHT) begin
      indicator_next = LVL_3;
      if (s >= r0 && s < r1) begin
        period_next = PER_SLOW; indicator_next = LVL_1;
      end else if (s >= r1 && s < r2) begin
        period_next = PER_MID;  indicator_next = LVL_2;
      end else if (s >= r2 && s < r3) begin
        period_next = PER_FAST; indicator_next = LVL_3;
      end else if (s >= r3) begin
        period_next = PER_TOP;  indicator_next = LVL_4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_phase    <= SP_START;
      shift_period   <= '0;
      indicator_bits <= '0;
    end else if (advance) begin
      speed_phase    <= speed_phase_next;
      shift_period   <= period_next;
      indicator_bits <= indicator_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jrls_shift.sv -----
`timescale 1ns / 1ps
`default_nettype none
module jrls_shift (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           advance,
  input  wire logic [jrls_pkg::SAMPLE_W-1:0]  sample,
  input  wire jrls_pkg::limits_t              limits,
  input  wire logic [jrls_pkg::PERIOD_W-1:0]  period,
  output logic      [jrls_pkg::LED_W-1:0]     pattern_next
);
  import jrls_pkg::*;

  localparam logic [2:0] SH_START  = 3'd0;
  localparam logic [2:0] SH_INIT   = 3'd1;
  localparam logic [2:0] SH_WAIT   = 3'd2;
  localparam logic [2:0] SH_LWAIT  = 3'd3;
  localparam logic [2:0] SH_RWAIT  = 3'd4;
  localparam logic [2:0] SH_LSHIFT = 3'd5;
  localparam logic [2:0] SH_RSHIFT = 3'd6;

  localparam logic [LED_W-1:0] LED_MSB = 8'h80;
  localparam logic [LED_W-1:0] LED_LSB = 8'h01;

  logic [2:0]               shift_phase, shift_phase_next;
  logic [PERIOD_W-1:0]      tick_count, tick_count_next, tick_base;
  logic [LED_W-1:0]         position_pattern;
  logic signed [EDGE_W-1:0] s;

  assign s = $signed({{(EDGE_W-SAMPLE_W){1'b0}}, sample});

  always_comb begin
    tick_base = tick_count;
    unique case (shift_phase)
      SH_START: shift_phase_next = SH_INIT;
      SH_INIT:  shift_phase_next = SH_WAIT;
      SH_WAIT: begin
        if (s < limits.lo) begin
          shift_phase_next = SH_LWAIT;
          tick_base        = '0;
        end else if (s > limits.hi) begin
          shift_phase_next = SH_RWAIT;
          tick_base        = '0;
        end else begin
          shift_phase_next = SH_WAIT;
        end
      end
      SH_LWAIT: shift_phase_next = (tick_count < period) ? SH_LWAIT : SH_LSHIFT;
      SH_RWAIT: shift_phase_next = (tick_count < period) ? SH_RWAIT : SH_RSHIFT;
      SH_LSHIFT, SH_RSHIFT: shift_phase_next = SH_WAIT;
      default: shift_phase_next = SH_START;
    endcase
  end

  always_comb begin
    tick_count_next = tick_base;
    pattern_next    = position_pattern;
    case (shift_phase_next)
      SH_INIT:  pattern_next = LED_MSB;
      SH_WAIT:  tick_count_next = '0;
      SH_LWAIT, SH_RWAIT: tick_count_next = tick_base + 7'd1;
      SH_LSHIFT: pattern_next = (position_pattern == LED_MSB) ? LED_LSB
                                : {position_pattern[LED_W-2:0], 1'b0};
      SH_RSHIFT: pattern_next = (position_pattern == LED_LSB) ? LED_MSB
                                : {1'b0, position_pattern[LED_W-1:1]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_phase      <= SH_START;
      tick_count       <= '0;
      position_pattern <= '0;
    end else if (advance) begin
      shift_phase      <= shift_phase_next;
      tick_count       <= tick_count_next;
      position_pattern <= pattern_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/joystick_rate_led_shifter_top.sv -----
// channel   signals                                      payload
// config    psel penable pwrite paddr pwdata prdata pready  five registers at 4*i
// sample    sample_valid sample_ready                     stick_sample
// result    result_valid result_ready                     led_position level_indicator
//
// one result word per sample word; sustained rate one word per cycle while result_ready stays high
// path: input register, then speed and shift update into the result register
// the input register advances whenever the result register is empty or being taken
// rst (synchronous) clears both machines, the counters and both valid flags
// a stalled result holds one sample in the input register, then sample_ready drops
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module joystick_rate_led_shifter_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [jrls_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [jrls_pkg::DATA_W-1:0]    pwdata,
  output logic      [jrls_pkg::DATA_W-1:0]    prdata,
  output logic                                pready,
  input  wire logic                           sample_valid,
  output logic                                sample_ready,
  input  wire logic [jrls_pkg::SAMPLE_W-1:0]  stick_sample,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output logic      [jrls_pkg::LED_W-1:0]     led_position,
  output logic      [jrls_pkg::LEVEL_W-1:0]   level_indicator
);
  import jrls_pkg::*;

  cfg_t                cfg;
  limits_t             limits;
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                advance;
  logic [PERIOD_W-1:0] period_next;
  logic [LEVEL_W-1:0]  indicator_next;
  logic [LED_W-1:0]    pattern_next;

  jrls_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // dead band limits, signed and unclipped
  assign limits.lo = $signed({{(EDGE_W-CENTRE_W){1'b0}}, cfg.centre_value})
                   - $signed({{(EDGE_W-DEAD_W){1'b0}}, cfg.dead_band});
  assign limits.hi = $signed({{(EDGE_W-CENTRE_W){1'b0}}, cfg.centre_value})
                   + $signed({{(EDGE_W-DEAD_W){1'b0}}, cfg.dead_band});

  assign advance      = s1_valid && (!result_valid || result_ready);
  assign sample_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_ready) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      s1_sample <= stick_sample;
    end
  end

  jrls_speed u_speed (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .sample         (s1_sample),
    .cfg            (cfg),
    .limits         (limits),
    .period_next    (period_next),
    .indicator_next (indicator_next)
  );

  // the shift machine sees the period chosen in the same tick
  jrls_shift u_shift (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .sample       (s1_sample),
    .limits       (limits),
    .period       (period_next),
    .pattern_next (pattern_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_position    <= pattern_next;
      level_indicator <= indicator_next;
    end
  end

  `ASSERT_CLK(a_led_onehot0, result_valid |-> $onehot0(led_position), "led pattern not one-hot")
  `ASSERT_CLK(a_level_onehot, result_valid |-> $onehot(level_indicator), "level not one-hot")
  `ASSERT_CLK(a_stall_only, !sample_ready |-> (s1_valid && result_valid && !result_ready), "input blocked without stall")
  `ASSERT_CLK(a_advance_fills, advance |=> result_valid, "result word lost after advance")
  `ASSERT_ALWAYS(a_rst_clears, rst |=> (!result_valid && !s1_valid), "valid flags survive reset")

endmodule
`default_nettype wire
